### rtl/lz4_frame_decompressor_defines.svh
// ----------------------------------------------------------------------------
// LZ4 frame decompressor assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef LZ4_FRAME_DECOMPRESSOR_DEFINES_SVH
`define LZ4_FRAME_DECOMPRESSOR_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define LZ4FD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define LZ4FD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/lz4fd_pkg.sv
// ----------------------------------------------------------------------------
// LZ4 frame decompressor package
// Types, codes and constants shared by the decompressor modules.
// ----------------------------------------------------------------------------
package lz4fd_pkg;

	localparam int HISTORY_DEPTH_DEF = 65536;
	localparam int OUT_LANES_DEF     = 8;

	localparam logic [31:0] MAGIC_LEGACY = 32'h184C_2102;
	localparam logic [31:0] MAGIC_STD    = 32'h184D_2204;

	localparam logic [31:0] MIN_FRAME   = 32'd7;
	localparam logic [31:0] SIZE_BYTES  = 32'd4;
	localparam logic [3:0]  FIELD_LAST  = 4'd3;
	localparam logic [3:0]  CSUM_LEN    = 4'd4;
	localparam logic [3:0]  HCSUM_LEN   = 4'd1;
	localparam logic [3:0]  CSIZE_LEN   = 4'd8;
	localparam logic [3:0]  DICT_LEN    = 4'd4;
	localparam logic [3:0]  NIB_EXT     = 4'hF;
	localparam logic [7:0]  BYTE_EXT    = 8'hFF;
	localparam logic [7:0]  MIN_MATCH   = 8'd4;
	localparam logic [5:0]  RES_CAP     = 6'd32;

	// Configuration register indexes
	localparam logic [1:0] REG_FRAME_LENGTH = 2'd0;
	localparam logic [1:0] REG_MAX_OUTPUT   = 2'd1;

	// Flag byte bit positions
	localparam int FLG_DICT  = 0;
	localparam int FLG_CSIZE = 3;
	localparam int FLG_BCSUM = 4;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_MAGIC   = 3'd1,
		ST_RAW     = 3'd2,
		ST_BLOCK   = 3'd3,
		ST_OUTOVF  = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		PH_MAGIC, PH_FLAGS, PH_DESC, PH_HSKIP, PH_BSIZE, PH_RAW, PH_TOK,
		PH_LITX, PH_LIT, PH_OFFL, PH_OFFH, PH_MATX, PH_CSUM, PH_DONE
	} phase_t;

	typedef enum logic [3:0] {
		S_IDLE, S_PRE, S_EXEC, S_PUT, S_RD, S_CPUT, S_POST,
		S_FFLUSH, S_FDONE, S_SFLUSH, S_LAST
	} seq_state_t;

	typedef enum logic [1:0] {
		PK_PUT, PK_FLUSH, PK_DONE, PK_LAST
	} pk_op_t;

	// Request from the sequencer to the output packer
	typedef struct packed {
		logic        vld;
		pk_op_t      op;
		logic [7:0]  data;
		logic        emit;
		status_t     status;
		logic [31:0] total;
	} pk_req_t;

	typedef struct packed {
		logic [31:0] total;
		status_t     status;
		logic        done;
		logic [3:0]  cnt;
		logic [63:0] data;
	} res_t;

endpackage

### rtl/lz4fd_hist.sv
// ----------------------------------------------------------------------------
// LZ4 history memory
// Byte-wide window of past output, one write and one registered read port.
// ----------------------------------------------------------------------------
module lz4fd_hist #(
	parameter int DEPTH = lz4fd_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [7:0]               wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [7:0]               rdata
);

	logic [7:0] mem [DEPTH];

	// Store output bytes
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Fetch a match byte, hold it until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/lz4fd_pack.sv
// ----------------------------------------------------------------------------
// LZ4 output packer
// Gathers output bytes into words, holds one result back to mark the last.
// ----------------------------------------------------------------------------
module lz4fd_pack #(
	parameter int OUT_LANES = lz4fd_pkg::OUT_LANES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lz4fd_pkg::pk_req_t  req,
	output logic                rdy,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [103:0]        m_tdata,  // out_bytes, out_count, status, out_total, pad
	output logic                m_tuser,  // done_res
	output logic                m_tlast
);
	import lz4fd_pkg::*;

	localparam int LW = 8 * OUT_LANES;
	localparam int FW = $clog2(OUT_LANES + 1);

	logic [LW-1:0] acc_q, acc_d;
	logic [FW-1:0] fill_q, fill_d;
	logic [5:0]    rn_q, rn_d;
	logic          pend_v_q;
	res_t          pend_q;
	logic          out_v_q, out_last_q;
	res_t          out_q;
	logic          nr_v, take, out_free;
	res_t          nr;

	assign out_free = !out_v_q || m_tready;
	assign rdy      = !pend_v_q || out_free;
	assign take     = req.vld && rdy;

	// Build words and results
	always_comb begin
		acc_d  = acc_q;
		fill_d = fill_q;
		rn_d   = rn_q;
		nr_v   = 1'b0;
		nr     = '0;
		if (take) begin
			case (req.op)
				PK_PUT: begin
					if (req.emit) begin
						for (int i = 0; i < OUT_LANES; i++) begin
							if (fill_q == FW'(i)) begin
								acc_d[i*8 +: 8] = req.data;
							end
						end
						if (fill_q == FW'(OUT_LANES - 1)) begin
							if (rn_q < RES_CAP) begin
								nr_v    = 1'b1;
								nr.data = 64'(acc_d);
								nr.cnt  = 4'(OUT_LANES);
								rn_d    = rn_q + 6'd1;
							end
							acc_d  = '0;
							fill_d = '0;
						end else begin
							fill_d = fill_q + FW'(1);
						end
					end
				end
				PK_FLUSH: begin
					if (fill_q != '0 && rn_q < RES_CAP) begin
						nr_v    = 1'b1;
						nr.data = 64'(acc_q);
						nr.cnt  = 4'(fill_q);
						rn_d    = rn_q + 6'd1;
					end
					acc_d  = '0;
					fill_d = '0;
				end
				PK_DONE: begin
					nr_v      = 1'b1;
					nr.done   = 1'b1;
					nr.status = req.status;
					nr.total  = req.total;
				end
				PK_LAST: begin
					rn_d = '0;
				end
				default: begin
					rn_d = rn_q;
				end
			endcase
		end
	end

	// Advance the held result and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			fill_q     <= '0;
			rn_q       <= '0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			acc_q  <= acc_d;
			fill_q <= fill_d;
			rn_q   <= rn_d;
			if (take && nr_v) begin
				pend_v_q <= 1'b1;
				if (pend_v_q) begin
					out_v_q    <= 1'b1;
					out_last_q <= 1'b0;
				end else if (m_tready) begin
					out_v_q <= 1'b0;
				end
			end else if (take && req.op == PK_LAST && pend_v_q) begin
				pend_v_q   <= 1'b0;
				out_v_q    <= 1'b1;
				out_last_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (take && nr_v) begin
			pend_q <= nr;
			if (pend_v_q) begin
				out_q <= pend_q;
			end
		end else if (take && req.op == PK_LAST && pend_v_q) begin
			out_q <= pend_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_q.done;
	assign m_tdata  = {1'b0, out_q.total, out_q.status, out_q.cnt, out_q.data};

endmodule

### rtl/lz4_frame_decompressor.sv
// ----------------------------------------------------------------------------
// LZ4 frame decompressor
// Byte-serial frame parser with a history copy unit and an output packer.
// ----------------------------------------------------------------------------
// Takes one frame byte per accepted item and returns zero or more results:
// data words of up to OUT_LANES bytes, then a done result with status and
// output length when the frame ends; tlast marks the final result of each
// item. Each byte of a match is read from the history memory's single
// registered read port and written back before the next read. A finish is
// taken straight from the decode when the byte itself ends the frame and
// after the byte's work when the end is found there, and any item waits
// longer while the output side stalls. The history memory needs no
// clearing pass after reset.
module lz4_frame_decompressor #(
	parameter int HISTORY_DEPTH = lz4fd_pkg::HISTORY_DEPTH_DEF,
	parameter int OUT_LANES     = lz4fd_pkg::OUT_LANES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // in_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,   // out_bytes, out_count, status, out_total, pad
	output logic         m_tuser,   // done_res
	output logic         m_tlast,   // last_result
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	import lz4fd_pkg::*;

	localparam int AW = $clog2(HISTORY_DEPTH);

	seq_state_t  st_q, st_d;
	phase_t      ph_q, ph_x, ph_p;
	logic [31:0] flen_q, maxo_q;
	logic [7:0]  b_q;
	logic [31:0] bc_q, bc1, left_q;
	logic [31:0] field_q, field_x, field_sh;
	logic        legacy_q, legacy_x;
	logic [7:0]  flags_q, flags_x;
	logic [3:0]  skip_q, skip_x, skip_p, skip_dec;
	logic [31:0] brem_q, brem_x, brem_dec;
	logic [31:0] lrem_q, lrem_x, lrem_dec;
	logic [32:0] lsum, raw_n, raw_out;
	logic [3:0]  nib_q, nib_x;
	logic [15:0] off_q, off_x;
	logic [31:0] ocnt_q, ocnt_inc;
	logic [AW-1:0] ptr_q;
	logic [7:0]  copy_q, copy_x;
	logic        lit_x, fin_x, bend_x, bend_q, fin_p;
	status_t     fst_x, fst_p, fst_q;
	pk_req_t     pk_req;
	logic        pk_rdy;
	logic        mem_we, mem_re;
	logic [7:0]  mem_rdata;

	assign cfg_ready = 1'b1;
	assign bc1       = (bc_q == '1) ? bc_q : bc_q + 32'd1;
	assign field_sh  = {b_q, field_q[31:8]};
	assign brem_dec  = (brem_q != '0) ? brem_q - 32'd1 : brem_q;
	assign lrem_dec  = (lrem_q != '0) ? lrem_q - 32'd1 : lrem_q;
	assign skip_dec  = (skip_q != '0) ? skip_q - 4'd1 : skip_q;
	assign lsum      = {1'b0, lrem_q} + 33'(b_q);
	assign raw_n     = {2'b00, field_sh[30:0]};
	assign raw_out   = {1'b0, ocnt_q} + raw_n;
	assign ocnt_inc  = (ocnt_q == '1) ? ocnt_q : ocnt_q + 32'd1;

	// Decode one frame byte against the parse phase
	always_comb begin
		ph_x     = ph_q;
		skip_x   = skip_q;
		field_x  = field_q;
		legacy_x = legacy_q;
		flags_x  = flags_q;
		brem_x   = brem_q;
		lrem_x   = lrem_q;
		nib_x    = nib_q;
		off_x    = off_q;
		lit_x    = 1'b0;
		copy_x   = '0;
		fin_x    = 1'b0;
		fst_x    = ST_OK;
		bend_x   = 1'b0;
		if (ph_q == PH_MAGIC && skip_q == '0 && flen_q < MIN_FRAME) begin
			fin_x = 1'b1;
			fst_x = ST_MAGIC;
		end else begin
			case (ph_q)
				PH_MAGIC: begin
					field_x = field_sh;
					skip_x  = skip_q + 4'd1;
					if (skip_q == FIELD_LAST) begin
						skip_x = '0;
						if (field_sh == MAGIC_LEGACY) begin
							legacy_x = 1'b1;
							if (left_q < SIZE_BYTES) begin
								fin_x = 1'b1;
							end else begin
								ph_x = PH_BSIZE;
							end
						end else if (field_sh == MAGIC_STD) begin
							ph_x = PH_FLAGS;
						end else begin
							fin_x = 1'b1;
							fst_x = ST_MAGIC;
						end
					end
				end
				PH_FLAGS: begin
					flags_x = b_q;
					ph_x    = PH_DESC;
				end
				PH_DESC: begin
					skip_x = HCSUM_LEN + (flags_q[FLG_CSIZE] ? CSIZE_LEN : 4'd0)
						+ (flags_q[FLG_DICT] ? DICT_LEN : 4'd0);
					ph_x   = PH_HSKIP;
				end
				PH_HSKIP, PH_CSUM: begin
					skip_x = skip_dec;
					if (skip_dec == '0) begin
						if (left_q < SIZE_BYTES) begin
							fin_x = 1'b1;
						end else begin
							ph_x = PH_BSIZE;
						end
					end
				end
				PH_BSIZE: begin
					field_x = field_sh;
					skip_x  = skip_q + 4'd1;
					if (skip_q == FIELD_LAST) begin
						skip_x = '0;
						if (field_sh == '0) begin
							fin_x = 1'b1;
						end else if (!legacy_q && field_sh[31]) begin
							if (raw_n > {1'b0, left_q} || raw_out > {1'b0, maxo_q}) begin
								fin_x = 1'b1;
								fst_x = ST_RAW;
							end else begin
								brem_x = raw_n[31:0];
								if (raw_n == '0) begin
									bend_x = 1'b1;
								end else begin
									ph_x = PH_RAW;
								end
							end
						end else if (field_sh > left_q) begin
							fin_x = 1'b1;
							fst_x = ST_BLOCK;
						end else begin
							brem_x = field_sh;
							ph_x   = PH_TOK;
						end
					end
				end
				PH_RAW: begin
					brem_x = brem_dec;
					lit_x  = 1'b1;
					bend_x = (brem_dec == '0);
				end
				PH_TOK, PH_LITX, PH_LIT, PH_OFFL, PH_OFFH, PH_MATX: begin
					brem_x = brem_dec;
					bend_x = (brem_dec == '0);
					case (ph_q)
						PH_TOK: begin
							nib_x  = b_q[3:0];
							lrem_x = 32'(b_q[7:4]);
							if (b_q[7:4] == NIB_EXT) begin
								ph_x = PH_LITX;
							end else begin
								ph_x = (b_q[7:4] != '0) ? PH_LIT : PH_OFFL;
							end
						end
						PH_LITX: begin
							lrem_x = lsum[32] ? '1 : lsum[31:0];
							if (b_q != BYTE_EXT) begin
								ph_x = (lrem_x != '0) ? PH_LIT : PH_OFFL;
							end
						end
						PH_LIT: begin
							lit_x  = 1'b1;
							lrem_x = lrem_dec;
							if (lrem_dec == '0) begin
								ph_x = PH_OFFL;
							end
						end
						PH_OFFL: begin
							off_x = {8'h00, b_q};
							ph_x  = PH_OFFH;
						end
						PH_OFFH: begin
							off_x  = {b_q, off_q[7:0]};
							copy_x = 8'(nib_q) + MIN_MATCH;
							ph_x   = (nib_q == NIB_EXT) ? PH_MATX : PH_TOK;
						end
						default: begin
							copy_x = b_q;
							if (b_q != BYTE_EXT) begin
								ph_x = PH_TOK;
							end
						end
					endcase
				end
				default: begin
					ph_x = ph_q;
				end
			endcase
		end
	end

	// Close a block and check for the end of input
	always_comb begin
		ph_p   = ph_q;
		skip_p = skip_q;
		fin_p  = 1'b0;
		fst_p  = ST_OK;
		if (bend_q) begin
			if (ocnt_q > maxo_q) begin
				fin_p = 1'b1;
				fst_p = ST_OUTOVF;
			end else if (!legacy_q && flags_q[FLG_BCSUM]) begin
				ph_p   = PH_CSUM;
				skip_p = CSUM_LEN;
			end else if (left_q < SIZE_BYTES) begin
				fin_p = 1'b1;
			end else begin
				ph_p   = PH_BSIZE;
				skip_p = '0;
			end
		end
		if (!fin_p && left_q == '0) begin
			fin_p = 1'b1;
			fst_p = ST_OK;
		end
	end

	// Sequencer next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE: begin
				if (s_tvalid && ph_q != PH_DONE) begin
					st_d = S_PRE;
				end
			end
			S_PRE: begin
				st_d = S_EXEC;
			end
			S_EXEC: begin
				if (fin_x) begin
					st_d = S_FFLUSH;
				end else if (lit_x) begin
					st_d = S_PUT;
				end else if (copy_x != '0) begin
					st_d = S_RD;
				end else begin
					st_d = S_POST;
				end
			end
			S_PUT: begin
				if (pk_rdy) begin
					st_d = S_POST;
				end
			end
			S_RD: begin
				st_d = S_CPUT;
			end
			S_CPUT: begin
				if (pk_rdy) begin
					st_d = (copy_q == 8'd1) ? S_POST : S_RD;
				end
			end
			S_POST: begin
				st_d = fin_p ? S_FFLUSH : S_SFLUSH;
			end
			S_FFLUSH: begin
				if (pk_rdy) begin
					st_d = S_FDONE;
				end
			end
			S_FDONE: begin
				if (pk_rdy) begin
					st_d = S_SFLUSH;
				end
			end
			S_SFLUSH: begin
				if (pk_rdy) begin
					st_d = S_LAST;
				end
			end
			S_LAST: begin
				if (pk_rdy) begin
					st_d = S_IDLE;
				end
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		s_tready      = 1'b0;
		mem_we        = 1'b0;
		mem_re        = 1'b0;
		pk_req        = '0;
		pk_req.data   = (st_q == S_PUT) ? b_q : mem_rdata;
		pk_req.emit   = (ocnt_q < maxo_q);
		pk_req.status = fst_q;
		pk_req.total  = ocnt_q;
		case (st_q)
			S_IDLE: begin
				s_tready = 1'b1;
			end
			S_PUT, S_CPUT: begin
				pk_req.vld = 1'b1;
				pk_req.op  = PK_PUT;
				mem_we     = pk_rdy;
			end
			S_RD: begin
				mem_re = 1'b1;
			end
			S_FFLUSH, S_SFLUSH: begin
				pk_req.vld = 1'b1;
				pk_req.op  = PK_FLUSH;
			end
			S_FDONE: begin
				pk_req.vld = 1'b1;
				pk_req.op  = PK_DONE;
			end
			S_LAST: begin
				pk_req.vld = 1'b1;
				pk_req.op  = PK_LAST;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// Control and parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			ph_q     <= PH_MAGIC;
			flen_q   <= '0;
			maxo_q   <= '0;
			bc_q     <= '0;
			left_q   <= '0;
			field_q  <= '0;
			legacy_q <= 1'b0;
			flags_q  <= '0;
			skip_q   <= '0;
			brem_q   <= '0;
			lrem_q   <= '0;
			nib_q    <= '0;
			off_q    <= '0;
			ocnt_q   <= '0;
			ptr_q    <= '0;
			copy_q   <= '0;
			bend_q   <= 1'b0;
			fst_q    <= ST_OK;
		end else begin
			st_q <= st_d;
			if (cfg_valid && cfg_index == REG_FRAME_LENGTH) begin
				flen_q <= cfg_data;
			end
			if (cfg_valid && cfg_index == REG_MAX_OUTPUT) begin
				maxo_q <= cfg_data;
			end
			case (st_q)
				S_PRE: begin
					bc_q   <= bc1;
					left_q <= (bc1 >= flen_q) ? '0 : flen_q - bc1;
				end
				S_EXEC: begin
					ph_q     <= fin_x ? PH_DONE : ph_x;
					skip_q   <= skip_x;
					field_q  <= field_x;
					legacy_q <= legacy_x;
					flags_q  <= flags_x;
					brem_q   <= brem_x;
					lrem_q   <= lrem_x;
					nib_q    <= nib_x;
					off_q    <= off_x;
					copy_q   <= copy_x;
					bend_q   <= bend_x;
					fst_q    <= fst_x;
				end
				S_PUT, S_CPUT: begin
					if (pk_rdy) begin
						ptr_q  <= ptr_q + AW'(1);
						ocnt_q <= ocnt_inc;
						copy_q <= (copy_q != '0) ? copy_q - 8'd1 : copy_q;
					end
				end
				S_POST: begin
					ph_q   <= fin_p ? PH_DONE : ph_p;
					skip_q <= skip_p;
					fst_q  <= fst_p;
				end
				default: begin
					bend_q <= bend_q;
				end
			endcase
		end
	end

	// Hold the accepted byte
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			b_q <= s_tdata;
		end
	end

	lz4fd_hist #(
		.DEPTH(HISTORY_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (mem_we),
		.waddr (ptr_q),
		.wdata (pk_req.data),
		.re    (mem_re),
		.raddr (ptr_q - off_q[AW-1:0]),
		.rdata (mem_rdata)
	);

	lz4fd_pack #(
		.OUT_LANES(OUT_LANES)
	) u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (pk_req),
		.rdy      (pk_rdy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

### rtl/lz4fd_chk.sv
// ----------------------------------------------------------------------------
// LZ4 frame decompressor port checker
// Watches the result channel of the top level.
// ----------------------------------------------------------------------------
`include "lz4_frame_decompressor_defines.svh"

module lz4fd_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [103:0] m_tdata,
	input logic         m_tuser,
	input logic         m_tlast
);

	// A stalled item holds
	`LZ4FD_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stall lost")

	// The done item is empty and closes its input byte
	`LZ4FD_ASSERT_NOW(a_done, m_tvalid && m_tuser, m_tdata[67:0] == 68'd0 && m_tlast, "bad done")

	// Data items carry one to eight bytes and no status
	`LZ4FD_ASSERT_NOW(a_data, m_tvalid && !m_tuser, m_tdata[67:64] != 4'd0 && m_tdata[67:64] <= 4'd8 && m_tdata[70:68] == 3'd0, "bad data")

	// Done status stays within its codes
	`LZ4FD_ASSERT_NOW(a_stat, m_tvalid && m_tuser, m_tdata[70:68] <= 3'd4, "bad status")

endmodule

bind lz4_frame_decompressor lz4fd_chk u_chk (.*);

### bench/lz4_frame_decompressor_test.sv
// ----------------------------------------------------------------------------
// LZ4 frame decompressor testbench
// Streams one standard frame through the block byte by byte. A behavioural
// decoder predicts every output word and the done item. The monitor checks
// them in order while both stream sides idle and stall in phases.
// ----------------------------------------------------------------------------
module lz4_frame_decompressor_test;
	import lz4fd_pkg::*;

	localparam int QUIET_CYCLES = 1500;
	localparam int CYCLE_LIMIT  = 3000000;
	localparam int LONG_HOLD    = 4000;

	typedef enum logic [1:0] { IT_BYTE, IT_CFG, IT_DRAIN } pend_kind_t;

	typedef struct {
		pend_kind_t  kind;
		logic [7:0]  b;
		logic [1:0]  idx;
		logic [31:0] val;
	} pend_t;

	typedef struct {
		logic [63:0] data;
		logic [3:0]  cnt;
		logic        done;
		logic [2:0]  st;
		logic [31:0] total;
		logic        last;
	} result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = 8'd0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;
	logic         m_tuser;
	logic         m_tlast;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [1:0]   cfg_index = 2'd0;
	logic [31:0]  cfg_data = 32'd0;

	pend_t   pend_q[$];
	result_t word_q[$];
	result_t step_q[$];
	int      errors = 0;
	int      accepted = 0;
	int      quiet = 0;
	longint  cycles = 0;
	bit      hold_done = 1'b0;

	// decoder copy of the block
	logic [31:0] frame_len, max_out;
	phase_t      ph;
	logic [31:0] consumed, shifter, blk_left, lit_left, out_cnt;
	logic        legacy;
	logic [7:0]  flags;
	logic [3:0]  skip, nib;
	logic [15:0] moff, hptr;
	logic [7:0]  hist [0:65535];
	logic [63:0] w_acc;
	int          w_fill;

	lz4_frame_decompressor u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function void push_word(logic [63:0] d, logic [3:0] c, logic dn, logic [2:0] s,
			logic [31:0] t);
		result_t r;
		if (step_q.size() >= 33) return;
		r.data = d; r.cnt = c; r.done = dn; r.st = s; r.total = t; r.last = 1'b0;
		step_q.push_back(r);
	endfunction

	function void flush_word();
		if (w_fill != 0 && step_q.size() < 32) push_word(w_acc, 4'(w_fill), 1'b0, ST_OK, 0);
		w_acc = 64'd0;
		w_fill = 0;
	endfunction

	function void put_byte(logic [7:0] b);
		hist[hptr] = b;
		hptr = hptr + 16'd1;
		if (out_cnt < max_out) begin
			w_acc = w_acc | (64'(b) << (8 * w_fill));
			w_fill++;
			if (w_fill >= 8) flush_word();
		end
		if (out_cnt != 32'hFFFF_FFFF) out_cnt = out_cnt + 32'd1;
	endfunction

	function void copy_match(int n);
		logic [15:0] a;
		for (int i = 0; i < n; i++) begin
			a = hptr - moff;
			put_byte(hist[a]);
		end
	endfunction

	function void finish(status_t s);
		flush_word();
		ph = PH_DONE;
		push_word(64'd0, 4'd0, 1'b1, s, out_cnt);
	endfunction

	function logic [31:0] input_left();
		return (consumed >= frame_len) ? 32'd0 : frame_len - consumed;
	endfunction

	function void enter_size();
		if (input_left() < SIZE_BYTES) begin
			finish(ST_OK);
			return;
		end
		ph = PH_BSIZE;
		skip = 4'd0;
	endfunction

	function void block_end();
		if (out_cnt > max_out) begin
			finish(ST_OUTOVF);
			return;
		end
		if (!legacy && flags[FLG_BCSUM]) begin
			ph = PH_CSUM;
			skip = CSUM_LEN;
		end else begin
			enter_size();
		end
	endfunction

	function void start_block(logic [31:0] v);
		logic [31:0] left, n;
		left = input_left();
		if (v == 0) begin
			finish(ST_OK);
			return;
		end
		if (!legacy && v[31]) begin
			n = v & 32'h7FFF_FFFF;
			if (n > left || (33'(out_cnt) + 33'(n) > 33'(max_out))) begin
				finish(ST_RAW);
				return;
			end
			blk_left = n;
			if (n == 0) block_end();
			else ph = PH_RAW;
			return;
		end
		if (v > left) begin
			finish(ST_BLOCK);
			return;
		end
		blk_left = v;
		ph = PH_TOK;
	endfunction

	function void sequence_byte(logic [7:0] b);
		case (ph)
			PH_TOK: begin
				nib = b[3:0];
				lit_left = 32'(b[7:4]);
				if (lit_left == 32'd15) ph = PH_LITX;
				else ph = (lit_left != 0) ? PH_LIT : PH_OFFL;
			end
			PH_LITX: begin
				if (32'hFFFF_FFFF - lit_left < 32'(b)) lit_left = 32'hFFFF_FFFF;
				else lit_left = lit_left + 32'(b);
				if (b != BYTE_EXT) ph = (lit_left != 0) ? PH_LIT : PH_OFFL;
			end
			PH_LIT: begin
				put_byte(b);
				if (lit_left != 0) lit_left = lit_left - 32'd1;
				if (lit_left == 0) ph = PH_OFFL;
			end
			PH_OFFL: begin
				moff = 16'(b);
				ph = PH_OFFH;
			end
			PH_OFFH: begin
				moff = {b, moff[7:0]};
				copy_match(int'(nib) + 4);
				ph = (nib == NIB_EXT) ? PH_MATX : PH_TOK;
			end
			default: begin
				copy_match(int'(b));
				if (b != BYTE_EXT) ph = PH_TOK;
			end
		endcase
	endfunction

	// Work out the results that one accepted item causes
	function void decode_byte(logic [7:0] b);
		logic    first;
		result_t r;
		if (ph == PH_DONE) return;
		step_q.delete();
		w_acc = 64'd0;
		w_fill = 0;
		first = (ph == PH_MAGIC && skip == 0);
		if (consumed != 32'hFFFF_FFFF) consumed = consumed + 32'd1;
		if (first && frame_len < MIN_FRAME) begin
			finish(ST_MAGIC);
		end else begin
			case (ph)
				PH_MAGIC: begin
					shifter = {b, shifter[31:8]};
					skip = skip + 4'd1;
					if (skip >= 4'd4) begin
						skip = 4'd0;
						if (shifter == MAGIC_LEGACY) begin
							legacy = 1'b1;
							enter_size();
						end else if (shifter == MAGIC_STD) begin
							ph = PH_FLAGS;
						end else begin
							finish(ST_MAGIC);
						end
					end
				end
				PH_FLAGS: begin
					flags = b;
					ph = PH_DESC;
				end
				PH_DESC: begin
					skip = HCSUM_LEN + (flags[FLG_CSIZE] ? CSIZE_LEN : 4'd0)
						+ (flags[FLG_DICT] ? DICT_LEN : 4'd0);
					ph = PH_HSKIP;
				end
				PH_HSKIP, PH_CSUM: begin
					if (skip != 0) skip = skip - 4'd1;
					if (skip == 0) enter_size();
				end
				PH_BSIZE: begin
					shifter = {b, shifter[31:8]};
					skip = skip + 4'd1;
					if (skip >= 4'd4) begin
						skip = 4'd0;
						start_block(shifter);
					end
				end
				PH_RAW: begin
					if (blk_left != 0) blk_left = blk_left - 32'd1;
					put_byte(b);
					if (blk_left == 0) block_end();
				end
				default: begin
					if (blk_left != 0) blk_left = blk_left - 32'd1;
					sequence_byte(b);
					if (blk_left == 0) block_end();
				end
			endcase
		end
		if (ph != PH_DONE && consumed >= frame_len) finish(ST_OK);
		flush_word();
		if (step_q.size() > 0) begin
			r = step_q.pop_back();
			r.last = 1'b1;
			step_q.push_back(r);
		end
		while (step_q.size() > 0) word_q.push_back(step_q.pop_front());
	endfunction

	// Stimulus building
	logic [7:0] blk_q[$];
	int n_bytes = 0;
	int safe_hist = 0;

	task push_byte(logic [7:0] b);
		pend_t p;
		p.kind = IT_BYTE; p.b = b; p.idx = 2'd0; p.val = 32'd0;
		pend_q.push_back(p);
		n_bytes++;
	endtask

	task push_cfg(logic [1:0] idx, logic [31:0] val);
		pend_t p;
		p.kind = IT_CFG; p.b = 8'd0; p.idx = idx; p.val = val;
		pend_q.push_back(p);
	endtask

	task push_drain();
		pend_t p;
		p.kind = IT_DRAIN; p.b = 8'd0; p.idx = 2'd0; p.val = 32'd0;
		pend_q.push_back(p);
	endtask

	// Append one sequence to the block under construction
	task add_seq(int nlit, int mlen, bit with_match);
		int hi, lo, r, lim, off;
		hi = (nlit >= 15) ? 15 : nlit;
		lo = with_match ? ((mlen - 4 >= 15) ? 15 : mlen - 4) : 0;
		blk_q.push_back({4'(hi), 4'(lo)});
		if (nlit >= 15) begin
			r = nlit - 15;
			while (r >= 255) begin
				blk_q.push_back(BYTE_EXT);
				r -= 255;
			end
			blk_q.push_back(8'(r));
		end
		repeat (nlit) blk_q.push_back(8'($urandom));
		safe_hist += nlit;
		if (with_match) begin
			lim = (safe_hist > 65535) ? 65535 : safe_hist;
			off = $urandom_range(lim, 1);
			blk_q.push_back(8'(off));
			blk_q.push_back(8'(off >> 8));
			if (lo == 15) begin
				r = mlen - 19;
				while (r >= 255) begin
					blk_q.push_back(BYTE_EXT);
					r -= 255;
				end
				blk_q.push_back(8'(r));
			end
			safe_hist += mlen;
		end
	endtask

	// Size word, body and block checksum
	task emit_block(bit raw, int len);
		logic [31:0] sz;
		sz = raw ? (32'h8000_0000 | 32'(len)) : 32'(len);
		for (int i = 0; i < 4; i++) push_byte(sz[8*i +: 8]);
		for (int i = 0; i < len; i++) push_byte(blk_q[i]);
		repeat (4) push_byte(8'($urandom));
		blk_q.delete();
	endtask

	task random_block();
		int kind, nseq, nlit, mlen, pre, saved, len;
		bit cut;
		kind = $urandom_range(99);
		if (kind < 15) begin
			len = $urandom_range(24, 1);
			repeat (len) blk_q.push_back(8'($urandom));
			safe_hist += len;
			emit_block(1'b1, len);
			return;
		end
		cut = (kind >= 85);
		nseq = $urandom_range(4, 1);
		pre = 0;
		saved = safe_hist;
		for (int s = 0; s < nseq; s++) begin
			pre = blk_q.size();
			saved = safe_hist;
			nlit = ($urandom_range(99) < 70) ? $urandom_range(6, 0) : $urandom_range(40, 7);
			if (safe_hist == 0 && nlit == 0) nlit = 1;
			mlen = ($urandom_range(99) < 90) ? $urandom_range(20, 4) : $urandom_range(80, 21);
			add_seq(nlit, mlen, !(s == nseq - 1 && $urandom_range(1)));
		end
		len = blk_q.size();
		if (cut && len - pre > 1) begin
			len = pre + $urandom_range(len - pre - 1, 1);
			safe_hist = saved;
		end
		emit_block(1'b0, len);
	endtask

	// Sender: one item or one register write in flight at a time
	function bit sender_idle();
		int mode;
		mode = (accepted / 50) % 4;
		if (mode == 1) return $urandom_range(99) < 48;
		if (mode == 3) return $urandom_range(99) < 13;
		return 1'b0;
	endfunction

	always @(posedge clk) begin
		logic        nv_s, nv_c;
		logic [7:0]  nd;
		logic [1:0]  ni;
		logic [31:0] nc;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				decode_byte(s_tdata);
				accepted++;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_FRAME_LENGTH) frame_len = cfg_data;
				else if (cfg_index == REG_MAX_OUTPUT) max_out = cfg_data;
			end
			if (word_q.size() != 0 || s_tvalid) quiet = 0;
			else quiet++;
			if (!(s_tvalid && !s_tready) && !(cfg_valid && !cfg_ready)) begin
				nv_s = 1'b0; nv_c = 1'b0;
				nd = s_tdata; ni = cfg_index; nc = cfg_data;
				if (pend_q.size() > 0) begin
					case (pend_q[0].kind)
						IT_BYTE: begin
							if (!sender_idle()) begin
								nv_s = 1'b1;
								nd = pend_q[0].b;
								void'(pend_q.pop_front());
							end
						end
						IT_CFG: begin
							if (word_q.size() == 0 && quiet >= QUIET_CYCLES
									&& !cfg_valid) begin
								nv_c = 1'b1;
								ni = pend_q[0].idx;
								nc = pend_q[0].val;
								void'(pend_q.pop_front());
							end
						end
						default: begin
							if (word_q.size() == 0 && quiet >= QUIET_CYCLES)
								void'(pend_q.pop_front());
						end
					endcase
				end
				s_tvalid <= nv_s;
				s_tdata <= nd;
				cfg_valid <= nv_c;
				cfg_index <= ni;
				cfg_data <= nc;
			end
		end
	end

	// Receiver: stall phases plus one long hold-off
	always @(posedge clk) begin
		int hold_left;
		int mode;
		if (arst_n) begin
			if (!hold_done && accepted >= 280) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			mode = (accepted / 50) % 4;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (mode == 2) begin
				m_tready <= ($urandom_range(99) >= 48);
			end else if (mode == 3) begin
				m_tready <= ($urandom_range(99) >= 13);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Monitor: compare each item against the oldest prediction
	always @(posedge clk) begin
		result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (word_q.size() == 0) begin
				$error("unexpected output item %h", m_tdata);
				errors++;
			end else begin
				e = word_q.pop_front();
				if (m_tdata[63:0] !== e.data) begin
					$error("out_bytes expected %h got %h", e.data, m_tdata[63:0]);
					errors++;
				end
				if (m_tdata[67:64] !== e.cnt) begin
					$error("out_count expected %0d got %0d", e.cnt, m_tdata[67:64]);
					errors++;
				end
				if (m_tdata[70:68] !== e.st) begin
					$error("status expected %0d got %0d", e.st, m_tdata[70:68]);
					errors++;
				end
				if (m_tdata[102:71] !== e.total) begin
					$error("out_total expected %0d got %0d", e.total, m_tdata[102:71]);
					errors++;
				end
				if (m_tuser !== e.done) begin
					$error("done_res expected %0d got %0d", e.done, m_tuser);
					errors++;
				end
				if (m_tlast !== e.last) begin
					$error("last_result expected %0d got %0d", e.last, m_tlast);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		frame_len = 0; max_out = 0; ph = PH_MAGIC; consumed = 0; shifter = 0;
		blk_left = 0; lit_left = 0; out_cnt = 0; legacy = 0; flags = 0;
		skip = 0; nib = 0; moff = 0; hptr = 0;

		// widest limits, standard header with every optional field
		push_cfg(REG_FRAME_LENGTH, 32'hFFFF_FFFF);
		push_cfg(REG_MAX_OUTPUT, 32'hFFFF_FFFF);
		for (int i = 0; i < 4; i++) push_byte(MAGIC_STD[8*i +: 8]);
		push_byte(8'h19);
		push_byte(8'h40);
		repeat (13) push_byte(8'($urandom));

		// raw block with extreme bytes, then an empty raw block
		blk_q = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE};
		safe_hist += 8;
		emit_block(1'b1, 8);
		emit_block(1'b1, 0);

		// literal extension, nibble-15 match, long match, trailing literals
		add_seq(20, 4, 1'b1);
		add_seq(0, 19, 1'b1);
		add_seq(2, 277, 1'b1);
		add_seq(5, 0, 1'b0);
		emit_block(1'b0, blk_q.size());

		while (n_bytes < 140) random_block();
		push_drain();
		push_cfg(REG_FRAME_LENGTH, 32'd50000);
		push_cfg(REG_MAX_OUTPUT, 32'h7FFF_FFFF);
		while (n_bytes < 260) random_block();
		push_cfg(REG_MAX_OUTPUT, 32'd123456);
		while (n_bytes < 400) random_block();

		// no room left: the next block ends in output overflow
		push_cfg(REG_MAX_OUTPUT, 32'd0);
		add_seq(3, 6, 1'b1);
		emit_block(1'b0, blk_q.size());
		repeat (3) push_byte(8'($urandom));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		wait (pend_q.size() == 0);
		@(posedge clk);
		while (s_tvalid || cfg_valid || word_q.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
		if (word_q.size() != 0) errors++;
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
